@@ hw/rtl/llc_pkg.sv @@
`timescale 1ns / 1ps

package llc_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_INS_FIRST  = 3'd1,
        OP_DEL_FIRST  = 3'd2,
        OP_INS_AFTER  = 3'd3,
        OP_DEL_AFTER  = 3'd4,
        OP_SET_VALUE  = 3'd5,
        OP_CUR_HEAD   = 3'd6,
        OP_CUR_NEXT   = 3'd7
    } t_op;

endpackage

@@ hw/rtl/llc_ram.sv @@
`timescale 1ns / 1ps

module llc_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 9,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hw/rtl/linked_list_with_cursor_core.sv @@
`timescale 1ns / 1ps
// Sequence: S_LINK, S_READ, S_RES, then the result word is registered on the output;
// an insert after that links a node adds S_WR2, a delete after that unlinks one adds
// S_LINK2 and S_WR2, set by the dependent read-then-write passes through the single
// write port of the link memory. A new word is taken only in S_IDLE, after S_RES.
// Reset (synchronous, active low): head, cursor and free list go null, pool count to 0.
// Memories are not cleared; no clearing pass, the block accepts right after reset.

module linked_list_with_cursor_core #(
    parameter int NODES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [llc_pkg::OP_W-1:0]      i_operation,
    input  logic signed [llc_pkg::VALUE_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_alloc_error,
    output logic                          o_first_valid,
    output logic signed [llc_pkg::VALUE_W-1:0] o_first_value,
    output logic                          o_is_active,
    output logic signed [llc_pkg::VALUE_W-1:0] o_active_value
);

    import llc_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LINK  = 6'b000010,
        S_LINK2 = 6'b000100,
        S_WR2   = 6'b001000,
        S_READ  = 6'b010000,
        S_RES   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [VALUE_W-1:0] r_data, n_data;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_cursor, n_cursor;
    logic [PW-1:0] r_free, n_free;
    logic [PW-1:0] r_fresh, n_fresh;
    logic [PW-1:0] r_wr_addr, n_wr_addr;
    logic [PW-1:0] r_wr_data, n_wr_data;
    logic          r_err, n_err;
    logic          r_out_valid, n_out_valid;
    logic          r_out_err, n_out_err;
    logic          r_out_fv, n_out_fv;
    logic          r_out_act, n_out_act;
    logic [VALUE_W-1:0] r_out_first, n_out_first;
    logic [VALUE_W-1:0] r_out_active, n_out_active;

    logic [PW-1:0] link_ra_ptr;
    logic [PW-1:0] link_rd_a, link_rd_b;
    logic          link_we;
    logic [PW-1:0] link_waddr, link_wdata;
    logic          val_we;
    logic [PW-1:0] val_waddr;
    logic [VALUE_W-1:0] val_rd_head, val_rd_cursor;

    logic          take_ok;
    logic [PW-1:0] take_ptr;
    logic          in_accept;
    logic          out_free;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_state == S_IDLE) begin
            link_ra_ptr = (t_op'(i_operation) == OP_DEL_FIRST) ? r_head : r_cursor;
        end else begin
            link_ra_ptr = link_rd_a;
        end
    end

    llc_ram #(
        .DEPTH(NODES),
        .DW   (PW)
    ) u_link_ram (
        .i_clk    (i_clk),
        .i_we     (link_we),
        .i_waddr  (link_waddr[AW-1:0]),
        .i_wdata  (link_wdata),
        .i_raddr_a(link_ra_ptr[AW-1:0]),
        .i_raddr_b(r_free[AW-1:0]),
        .o_rdata_a(link_rd_a),
        .o_rdata_b(link_rd_b)
    );

    llc_ram #(
        .DEPTH(NODES),
        .DW   (VALUE_W)
    ) u_value_ram (
        .i_clk    (i_clk),
        .i_we     (val_we),
        .i_waddr  (val_waddr[AW-1:0]),
        .i_wdata  (r_data),
        .i_raddr_a(r_head[AW-1:0]),
        .i_raddr_b(r_cursor[AW-1:0]),
        .o_rdata_a(val_rd_head),
        .o_rdata_b(val_rd_cursor)
    );

    // node allocation: released nodes first, then the unused pool
    always_comb begin
        take_ok  = 1'b0;
        take_ptr = r_fresh;
        if (r_free != NIL) begin
            take_ok  = 1'b1;
            take_ptr = r_free;
        end else if (r_fresh != NIL) begin
            take_ok  = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_data       = r_data;
        n_head       = r_head;
        n_cursor     = r_cursor;
        n_free       = r_free;
        n_fresh      = r_fresh;
        n_wr_addr    = r_wr_addr;
        n_wr_data    = r_wr_data;
        n_err        = r_err;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_err    = r_out_err;
        n_out_fv     = r_out_fv;
        n_out_act    = r_out_act;
        n_out_first  = r_out_first;
        n_out_active = r_out_active;
        link_we      = 1'b0;
        link_waddr   = r_wr_addr;
        link_wdata   = r_wr_data;
        val_we       = 1'b0;
        val_waddr    = take_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op    = t_op'(i_operation);
                    n_data  = i_value;
                    n_err   = 1'b0;
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                n_state = S_READ;
                case (r_op)
                    OP_CLEAR: begin
                        n_head   = NIL;
                        n_cursor = NIL;
                        n_free   = NIL;
                        n_fresh  = '0;
                    end
                    OP_INS_FIRST: begin
                        if (!take_ok) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_free != NIL) begin
                                n_free = link_rd_b;
                            end else begin
                                n_fresh = r_fresh + PW'(1);
                            end
                            val_we     = 1'b1;
                            link_we    = 1'b1;
                            link_waddr = take_ptr;
                            link_wdata = r_head;
                            n_head     = take_ptr;
                        end
                    end
                    OP_DEL_FIRST: begin
                        if (r_head != NIL) begin
                            if (r_cursor == r_head) begin
                                n_cursor = NIL;
                            end
                            n_head     = link_rd_a;
                            link_we    = 1'b1;
                            link_waddr = r_head;
                            link_wdata = r_free;
                            n_free     = r_head;
                        end
                    end
                    OP_INS_AFTER: begin
                        if (r_cursor != NIL) begin
                            if (!take_ok) begin
                                n_err = 1'b1;
                            end else begin
                                if (r_free != NIL) begin
                                    n_free = link_rd_b;
                                end else begin
                                    n_fresh = r_fresh + PW'(1);
                                end
                                val_we     = 1'b1;
                                link_we    = 1'b1;
                                link_waddr = take_ptr;
                                link_wdata = link_rd_a;
                                n_wr_addr  = r_cursor;
                                n_wr_data  = take_ptr;
                                n_state    = S_WR2;
                            end
                        end
                    end
                    OP_DEL_AFTER: begin
                        if (r_cursor != NIL && link_rd_a != NIL) begin
                            n_wr_addr = link_rd_a;
                            n_state   = S_LINK2;
                        end
                    end
                    OP_SET_VALUE: begin
                        if (r_cursor != NIL) begin
                            val_we    = 1'b1;
                            val_waddr = r_cursor;
                        end
                    end
                    OP_CUR_HEAD: begin
                        n_cursor = r_head;
                    end
                    OP_CUR_NEXT: begin
                        if (r_cursor != NIL) begin
                            n_cursor = link_rd_a;
                        end
                    end
                    default: begin
                        n_state = S_READ;
                    end
                endcase
            end
            S_LINK2: begin
                // link_rd_a holds the successor of the victim
                link_we    = 1'b1;
                link_waddr = r_cursor;
                link_wdata = link_rd_a;
                n_wr_data  = r_free;
                n_free     = r_wr_addr;
                n_state    = S_WR2;
            end
            S_WR2: begin
                link_we = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_err    = r_err;
                    n_out_fv     = (r_head != NIL);
                    n_out_act    = (r_cursor != NIL);
                    n_out_first  = (r_head != NIL) ? val_rd_head : '0;
                    n_out_active = (r_cursor != NIL) ? val_rd_cursor : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_cursor    <= NIL;
            r_free      <= NIL;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cursor    <= n_cursor;
            r_free      <= n_free;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_data       <= n_data;
        r_wr_addr    <= n_wr_addr;
        r_wr_data    <= n_wr_data;
        r_err        <= n_err;
        r_out_err    <= n_out_err;
        r_out_fv     <= n_out_fv;
        r_out_act    <= n_out_act;
        r_out_first  <= n_out_first;
        r_out_active <= n_out_active;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_alloc_error  = r_out_err;
    assign o_first_valid  = r_out_fv;
    assign o_first_value  = r_out_first;
    assign o_is_active    = r_out_act;
    assign o_active_value = r_out_active;

`ifndef SYNTHESIS
    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor != NIL) |-> (r_head != NIL))
        else $error("cursor set on empty list");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NIL)
        else $error("pool count beyond node count");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_LINK))
        else $error("accepted word did not start the sequence");

    a_err_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && r_err) |-> (r_op == OP_INS_FIRST || r_op == OP_INS_AFTER))
        else $error("alloc error on non-insert operation");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_first_valid) |-> (o_first_value == '0))
        else $error("head value nonzero on empty list");
`endif

endmodule

@@ sim/linked_list_with_cursor_core_test.sv @@
`timescale 1ns / 1ps

module linked_list_with_cursor_core_test;

    import llc_pkg::*;

    localparam int NODES      = 256;
    localparam int PTR_W      = 9;
    localparam int IDLE_LIMIT = 2000;
    localparam int PRINT_CAP  = 40;

    typedef logic [PTR_W-1:0] node_ptr_t;
    localparam node_ptr_t NIL = 9'd256;

    typedef struct packed {
        logic        alloc_error;
        logic        first_valid;
        logic [31:0] first_value;
        logic        is_active;
        logic [31:0] active_value;
    } list_view_t;

    typedef struct packed {
        t_op         op;
        logic [31:0] data;
        logic        typed_in;
        list_view_t  want;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_operation;
    logic [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_alloc_error;
    logic        o_first_valid;
    logic [31:0] o_first_value;
    logic        o_is_active;
    logic [31:0] o_active_value;

    linked_list_with_cursor_core #(
        .NODES(NODES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_alloc_error  (o_alloc_error),
        .o_first_valid  (o_first_valid),
        .o_first_value  (o_first_value),
        .o_is_active    (o_is_active),
        .o_active_value (o_active_value)
    );

    // list model
    node_ptr_t   node_link [NODES];
    logic [31:0] node_data [NODES];
    node_ptr_t   head_p;
    node_ptr_t   cur_p;
    node_ptr_t   free_p;
    int          fresh_cnt;

    list_view_t  expected_views [$];
    logic        lit_en;
    list_view_t  lit_view;

    int words_sent;
    int results_seen;
    int refusals;
    int clears;
    int mismatches;
    int idle_cycles;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic node_ptr_t grab_node();
        node_ptr_t n;
        if (free_p != NIL) begin
            n = free_p;
            free_p = node_link[n];
        end else if (fresh_cnt < NODES) begin
            n = node_ptr_t'(fresh_cnt);
            fresh_cnt++;
        end else begin
            n = NIL;
        end
        return n;
    endfunction

    function automatic void release_node(node_ptr_t n);
        node_link[n] = free_p;
        free_p = n;
    endfunction

    function automatic list_view_t step_list(t_op op, logic [31:0] data);
        list_view_t v;
        logic       err;
        node_ptr_t  n;
        node_ptr_t  victim;
        err = 1'b0;
        case (op)
            OP_CLEAR: begin
                head_p = NIL;
                cur_p = NIL;
                free_p = NIL;
                fresh_cnt = 0;
            end
            OP_INS_FIRST: begin
                n = grab_node();
                if (n == NIL) begin
                    err = 1'b1;
                end else begin
                    node_data[n] = data;
                    node_link[n] = head_p;
                    head_p = n;
                end
            end
            OP_DEL_FIRST: begin
                if (head_p != NIL) begin
                    victim = head_p;
                    if (cur_p == victim) cur_p = NIL;
                    head_p = node_link[victim];
                    release_node(victim);
                end
            end
            OP_INS_AFTER: begin
                if (cur_p != NIL) begin
                    n = grab_node();
                    if (n == NIL) begin
                        err = 1'b1;
                    end else begin
                        node_data[n] = data;
                        node_link[n] = node_link[cur_p];
                        node_link[cur_p] = n;
                    end
                end
            end
            OP_DEL_AFTER: begin
                if (cur_p != NIL && node_link[cur_p] != NIL) begin
                    victim = node_link[cur_p];
                    node_link[cur_p] = node_link[victim];
                    release_node(victim);
                end
            end
            OP_SET_VALUE: begin
                if (cur_p != NIL) node_data[cur_p] = data;
            end
            OP_CUR_HEAD: begin
                cur_p = head_p;
            end
            default: begin
                if (cur_p != NIL) cur_p = node_link[cur_p];
            end
        endcase
        v.alloc_error  = err;
        v.first_valid  = (head_p != NIL);
        v.first_value  = (head_p != NIL) ? node_data[head_p] : 32'h0;
        v.is_active    = (cur_p != NIL);
        v.active_value = (cur_p != NIL) ? node_data[cur_p] : 32'h0;
        return v;
    endfunction

    function automatic list_view_t lv(logic err, logic fv, logic [31:0] fval,
                                      logic act, logic [31:0] aval);
        list_view_t v;
        v.alloc_error  = err;
        v.first_valid  = fv;
        v.first_value  = fval;
        v.is_active    = act;
        v.active_value = aval;
        return v;
    endfunction

    function automatic t_op pick_op(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 55) return OP_INS_FIRST;
            if (r < 85) return OP_INS_AFTER;
            if (r < 89) return OP_CUR_NEXT;
            if (r < 93) return OP_CUR_HEAD;
            if (r < 96) return OP_SET_VALUE;
            if (r < 98) return OP_DEL_AFTER;
            return OP_DEL_FIRST;
        end
        if (r < 3)  return OP_CLEAR;
        if (r < 22) return OP_INS_FIRST;
        if (r < 37) return OP_DEL_FIRST;
        if (r < 55) return OP_INS_AFTER;
        if (r < 66) return OP_DEL_AFTER;
        if (r < 74) return OP_SET_VALUE;
        if (r < 84) return OP_CUR_HEAD;
        return OP_CUR_NEXT;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(t_op op, logic [31:0] data, logic typed_in, list_view_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= data;
        lit_en      <= typed_in;
        lit_view    <= want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_views.size() != 0) @(negedge i_clk);
    endtask

    // receiver stall pattern in one of four modes, each picked at random in turn
    initial begin
        int mode_cycles;
        int stall_mode;
        int run_len;
        logic stall_hold;
        mode_cycles = 0;
        stall_mode = 0;
        run_len = 0;
        stall_hold = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_cycles == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_cycles = $urandom_range(100, 300);
            end
            mode_cycles--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                2: begin
                    if (run_len == 0) begin
                        stall_hold = !stall_hold;
                        run_len = stall_hold ? $urandom_range(1, 16) : $urandom_range(1, 8);
                    end
                    run_len--;
                    i_out_stall <= stall_hold;
                end
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        list_view_t pred;
        list_view_t want;
        logic       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                pred = step_list(t_op'(i_operation), i_value);
                if (pred.alloc_error) refusals++;
                if (t_op'(i_operation) == OP_CLEAR) clears++;
                words_sent++;
                expected_views.push_back(lit_en ? lit_view : pred);
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_seen++;
                if (expected_views.size() == 0) begin
                    report_mismatch("unexpected word", 32'h0, 32'h0);
                end else begin
                    want = expected_views.pop_front();
                    if (o_alloc_error !== want.alloc_error)
                        report_mismatch("alloc_error", 32'(o_alloc_error),
                                        32'(want.alloc_error));
                    if (o_first_valid !== want.first_valid)
                        report_mismatch("first_valid", 32'(o_first_valid),
                                        32'(want.first_valid));
                    if (o_first_value !== want.first_value)
                        report_mismatch("first_value", o_first_value, want.first_value);
                    if (o_is_active !== want.is_active)
                        report_mismatch("is_active", 32'(o_is_active), 32'(want.is_active));
                    if (o_active_value !== want.active_value)
                        report_mismatch("active_value", o_active_value, want.active_value);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("linked_list_with_cursor_core_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t dir_rows [$];
        int        fill_goal;
        int        fill_sent;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_CLEAR;
        i_value     = 32'h0;
        lit_en      = 1'b0;
        lit_view    = '0;
        head_p      = NIL;
        cur_p       = NIL;
        free_p      = NIL;
        fresh_cnt   = 0;
        words_sent  = 0;
        results_seen = 0;
        refusals    = 0;
        clears      = 0;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;

        // empty-list no-ops, cursor walk off the tail, delete of the cursor node
        dir_rows = '{
            '{OP_CUR_NEXT,  32'h0000_0000, 1'b1, lv(0, 0, 32'h0, 0, 32'h0)},
            '{OP_DEL_FIRST, 32'h0000_0000, 1'b1, lv(0, 0, 32'h0, 0, 32'h0)},
            '{OP_INS_AFTER, 32'h1111_1111, 1'b1, lv(0, 0, 32'h0, 0, 32'h0)},
            '{OP_DEL_AFTER, 32'h0000_0000, 1'b1, lv(0, 0, 32'h0, 0, 32'h0)},
            '{OP_SET_VALUE, 32'hDEAD_BEEF, 1'b1, lv(0, 0, 32'h0, 0, 32'h0)},
            '{OP_CUR_HEAD,  32'h0000_0000, 1'b1, lv(0, 0, 32'h0, 0, 32'h0)},
            '{OP_INS_FIRST, 32'h7FFF_FFFF, 1'b1, lv(0, 1, 32'h7FFF_FFFF, 0, 32'h0)},
            '{OP_CUR_HEAD,  32'h0000_0000, 1'b1,
              lv(0, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF)},
            '{OP_INS_AFTER, 32'h8000_0000, 1'b1,
              lv(0, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF)},
            '{OP_CUR_NEXT,  32'h0000_0000, 1'b1,
              lv(0, 1, 32'h7FFF_FFFF, 1, 32'h8000_0000)},
            '{OP_CUR_NEXT,  32'h0000_0000, 1'b1, lv(0, 1, 32'h7FFF_FFFF, 0, 32'h0)},
            '{OP_CUR_HEAD,  32'h0000_0000, 1'b0, '0},
            '{OP_DEL_AFTER, 32'h0000_0000, 1'b0, '0},
            '{OP_DEL_AFTER, 32'h0000_0000, 1'b0, '0},
            '{OP_SET_VALUE, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_INS_FIRST, 32'h0000_0000, 1'b0, '0},
            '{OP_INS_FIRST, 32'h5555_5555, 1'b0, '0},
            '{OP_CUR_NEXT,  32'h0000_0000, 1'b0, '0},
            '{OP_DEL_FIRST, 32'h0000_0000, 1'b0, '0},
            '{OP_CUR_HEAD,  32'h0000_0000, 1'b0, '0},
            '{OP_DEL_FIRST, 32'h0000_0000, 1'b0, '0},
            '{OP_INS_AFTER, 32'hAAAA_AAAA, 1'b0, '0},
            '{OP_CLEAR,     32'h0000_0000, 1'b1, lv(0, 0, 32'h0, 0, 32'h0)},
            '{OP_INS_FIRST, 32'h1234_5678, 1'b1, lv(0, 1, 32'h1234_5678, 0, 32'h0)}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_word(dir_rows[k].op, dir_rows[k].data, dir_rows[k].typed_in, dir_rows[k].want);
        wait_drained();

        repeat (100) send_word(pick_op(1'b0), pick_value(), 1'b0, '0);
        wait_drained();

        // grow the list until the pool runs dry six times, at most 700 words
        fill_goal = refusals + 6;
        fill_sent = 0;
        while (refusals < fill_goal && fill_sent < 700) begin
            send_word(pick_op(1'b1), pick_value(), 1'b0, '0);
            fill_sent++;
        end
        // churn near full: freed nodes get reused
        repeat (40) send_word(pick_op(1'b0), pick_value(), 1'b0, '0);
        send_word(OP_CLEAR, pick_value(), 1'b0, '0);
        repeat (60) send_word(pick_op(1'b0), pick_value(), 1'b0, '0);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d words (%0d directed), %0d results compared,",
                 words_sent, dir_rows.size(), results_seen);
        $display("%0d inserts refused on a full pool, %0d clears, %0d mismatches",
                 refusals, clears, mismatches);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("linked_list_with_cursor_core_test OK");
        end else begin
            $display("linked_list_with_cursor_core_test NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/llc_pkg.sv
hw/rtl/llc_ram.sv
hw/rtl/linked_list_with_cursor_core.sv
sim/linked_list_with_cursor_core_test.sv
